// File: hdl/ultrasonic_echo_ranger_defines.svh
// Assertion macros shared by the ultrasonic echo ranger RTL.
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define UER_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define UER_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/uer_pkg.sv
// Shared types and constants of the ultrasonic echo ranger.
package uer_pkg;

    localparam int TIMER_BITS  = 16;
    localparam int TICKS_W     = 16;
    localparam int DIST_W      = 19;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [TICKS_W-1:0] TICKS_MAX = {TICKS_W{1'b1}};
    localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_HIGH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCALE       = 2'd3;

    // Configuration reset values.
    localparam logic [7:0]  SETTLE_LOW_RST = 8'd2;
    localparam logic [7:0]  PULSE_HIGH_RST = 8'd12;
    localparam logic [15:0] TIMEOUT_RST    = 16'd30000;
    localparam logic [15:0] SCALE_RST      = 16'd1114;

    typedef struct packed {
        logic [7:0]  settle_low_ticks;
        logic [7:0]  pulse_high_ticks;
        logic [15:0] timeout_ticks;
        logic [15:0] scale_factor;
    } uer_cfg_t;

    typedef struct packed {
        logic start_request;
        logic echo_level;
    } uer_in_t;

    typedef struct packed {
        logic               trigger_level;
        logic               busy_res;
        logic               done_pulse;
        logic               status;
        logic [TICKS_W-1:0] echo_ticks;
    } uer_stage_t;

    typedef struct packed {
        logic               trigger_level;
        logic               busy_res;
        logic               done_pulse;
        logic               status;
        logic [TICKS_W-1:0] echo_ticks;
        logic [DIST_W-1:0]  distance_q8;
    } uer_out_t;

endpackage

// File: hdl/uer_seq.sv
// Input register, trigger and echo sequencer, and the per-request status stage.
`include "ultrasonic_echo_ranger_defines.svh"

module uer_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tick_valid,
    output logic                tick_ready,
    input  uer_pkg::uer_in_t    tick,
    input  uer_pkg::uer_cfg_t   cfg,
    output logic                stage_valid,
    input  logic                stage_ready,
    output uer_pkg::uer_stage_t stage
);
    import uer_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_SETTLE    = 5'b00010,
        PH_PULSE     = 5'b00100,
        PH_WAIT_RISE = 5'b01000,
        PH_WAIT_FALL = 5'b10000
    } uer_phase_t;

    logic                  in_valid_reg;
    uer_in_t               in_reg;
    logic                  stage_valid_reg;
    uer_stage_t            stage_reg;
    uer_stage_t            stage_next;

    uer_phase_t            phase_reg, phase_next;
    logic [15:0]           count_reg, count_next;
    logic [TIMER_BITS-1:0] timer_reg;
    logic [TIMER_BITS-1:0] rise_stamp_reg, rise_stamp_next;
    logic                  echo_prev_reg;
    logic [TICKS_W-1:0]    last_width_reg, last_width_next;
    logic                  last_status_reg, last_status_next;

    logic                  stage_free;
    logic                  step;
    logic                  rise;
    logic                  fall;
    logic                  done;
    logic [15:0]           count_inc;
    logic [TIMER_BITS-1:0] pulse_span;
    logic [31:0]           pulse_span_ext;
    logic [TICKS_W-1:0]    pulse_width;

    assign stage_free = !stage_valid_reg || stage_ready;
    assign step       = in_valid_reg && stage_free;
    assign tick_ready = !in_valid_reg || stage_free;

    assign rise = in_reg.echo_level && !echo_prev_reg;
    assign fall = !in_reg.echo_level && echo_prev_reg;

    assign count_inc      = count_reg + 16'd1;
    assign pulse_span     = timer_reg - rise_stamp_reg;
    assign pulse_span_ext = 32'(pulse_span);
    // A wider timer can give a span beyond the result field; it saturates.
    assign pulse_width    = (pulse_span_ext > 32'(TICKS_MAX)) ? TICKS_MAX
                                                              : pulse_span_ext[TICKS_W-1:0];

    always_comb
    begin
        phase_next       = phase_reg;
        count_next       = count_reg;
        rise_stamp_next  = rise_stamp_reg;
        last_width_next  = last_width_reg;
        last_status_next = last_status_reg;
        done             = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (in_reg.start_request)
                begin
                    phase_next = PH_SETTLE;
                    count_next = 16'd1;
                end
            end
            PH_SETTLE:
            begin
                if (count_reg >= 16'(cfg.settle_low_ticks))
                begin
                    phase_next = PH_PULSE;
                    count_next = 16'd1;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            PH_PULSE:
            begin
                if (count_reg >= 16'(cfg.pulse_high_ticks))
                begin
                    phase_next = PH_WAIT_RISE;
                    count_next = 16'd0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            PH_WAIT_RISE, PH_WAIT_FALL:
            begin
                if (phase_reg == PH_WAIT_RISE && rise)
                begin
                    rise_stamp_next = timer_reg;
                    phase_next      = PH_WAIT_FALL;
                end
                else if (phase_reg == PH_WAIT_FALL && fall)
                begin
                    last_width_next  = pulse_width;
                    last_status_next = 1'b0;
                    done             = 1'b1;
                    phase_next       = PH_IDLE;
                    count_next       = 16'd0;
                end
                else if (count_inc >= cfg.timeout_ticks)
                begin
                    // No falling edge in time: report a timeout with zero width.
                    last_width_next  = '0;
                    last_status_next = 1'b1;
                    done             = 1'b1;
                    phase_next       = PH_IDLE;
                    count_next       = 16'd0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                count_next = 16'd0;
            end
        endcase

        stage_next.trigger_level = (phase_next == PH_PULSE);
        stage_next.busy_res      = (phase_next != PH_IDLE);
        stage_next.done_pulse    = done;
        stage_next.status        = last_status_next;
        stage_next.echo_ticks    = last_width_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            stage_valid_reg <= 1'b0;
            phase_reg       <= PH_IDLE;
            count_reg       <= '0;
            timer_reg       <= '0;
            rise_stamp_reg  <= '0;
            echo_prev_reg   <= 1'b0;
            last_width_reg  <= '0;
            last_status_reg <= 1'b0;
        end
        else
        begin
            if (tick_ready)
            begin
                in_valid_reg <= tick_valid;
            end
            if (stage_free)
            begin
                stage_valid_reg <= in_valid_reg;
            end
            if (step)
            begin
                phase_reg       <= phase_next;
                count_reg       <= count_next;
                timer_reg       <= timer_reg + TIMER_BITS'(1);
                rise_stamp_reg  <= rise_stamp_next;
                echo_prev_reg   <= in_reg.echo_level;
                last_width_reg  <= last_width_next;
                last_status_reg <= last_status_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_valid && tick_ready)
        begin
            in_reg <= tick;
        end
        if (step)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_valid = stage_valid_reg;
    assign stage       = stage_reg;

    `UER_ASSERT_NOW(a_done_ends_busy, stage_valid_reg && stage_reg.done_pulse,
        !stage_reg.busy_res && !stage_reg.trigger_level, "completion while still busy")
    `UER_ASSERT_NEXT(a_stage_holds, stage_valid_reg && !stage_ready,
        stage_valid_reg && $stable(stage_reg), "stalled stage changed")
    `UER_ASSERT_NEXT(a_timer_steps, step,
        timer_reg == TIMER_BITS'($past(timer_reg) + TIMER_BITS'(1)),
        "timer did not advance with a request")

endmodule

// File: hdl/uer_scale.sv
// Distance scaling and the result register.
`include "ultrasonic_echo_ranger_defines.svh"

module uer_scale (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [15:0]         scale_factor,
    input  logic                stage_valid,
    output logic                stage_ready,
    input  uer_pkg::uer_stage_t stage,
    output logic                result_valid,
    input  logic                result_ready,
    output uer_pkg::uer_out_t   result
);
    import uer_pkg::*;

    logic               result_valid_reg;
    uer_out_t           result_reg;
    logic [DIST_W-1:0]  dist_hold_reg;

    logic               advance;
    logic [31:0]        product;
    logic [32:0]        rounded;
    logic [24:0]        scaled;
    logic [DIST_W-1:0]  dist_new;
    logic [DIST_W-1:0]  dist_sel;

    assign advance     = !result_valid_reg || result_ready;
    assign stage_ready = advance;

    // Q16.0 width times Q0.16 factor, rounded half up to Q.8 and saturated.
    assign product  = 32'(stage.echo_ticks) * 32'(scale_factor);
    assign rounded  = 33'(product) + 33'd128;
    assign scaled   = rounded[32:8];
    assign dist_new = (scaled > 25'(DIST_MAX)) ? DIST_MAX : scaled[DIST_W-1:0];
    // The distance is only recomputed on completion and held otherwise.
    assign dist_sel = stage.done_pulse ? dist_new : dist_hold_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            dist_hold_reg    <= '0;
        end
        else if (advance)
        begin
            result_valid_reg <= stage_valid;
            if (stage_valid)
            begin
                dist_hold_reg <= dist_sel;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage_valid)
        begin
            result_reg.trigger_level <= stage.trigger_level;
            result_reg.busy_res      <= stage.busy_res;
            result_reg.done_pulse    <= stage.done_pulse;
            result_reg.status        <= stage.status;
            result_reg.echo_ticks    <= stage.echo_ticks;
            result_reg.distance_q8   <= dist_sel;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `UER_ASSERT_NOW(a_timeout_zero, result_valid_reg && result_reg.status,
        result_reg.distance_q8 == '0 && result_reg.echo_ticks == '0,
        "timeout result carries a distance")

endmodule

// File: hdl/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: configuration registers and pipeline.
//
// Ultrasonic echo ranger. Every request on the tick channel stands for one
// 1 us tick and carries a start request and the sampled echo pin level; every
// request gives exactly one result carrying the trigger pin level, busy, a
// one-tick done pulse, the held status (0 distance valid, 1 timeout), the held
// echo width in ticks and the held distance in centimetres as Q11.8. A start
// while idle holds trigger low for settle_low_ticks ticks (the start tick being
// the first), high for pulse_high_ticks ticks, then waits for an echo rising
// and falling edge; the width is the difference of the two free-running timer
// stamps modulo 2^16, scaled by scale_factor (Q0.16 cm per tick) and rounded
// half up. If no falling edge arrives within timeout_ticks waiting ticks (the
// tick of the rising edge not counted) a timeout is reported. Zero in a
// tick-count register acts as one. The block takes one request per clock as
// long as its results are taken. A request passes through the input register,
// the sequencer stage, which registers the control fields, and the scaling
// stage, which fills the result register, before its result is offered. The
// rate is set by the sequencer, which steps once for each tick. Every stage
// has its own valid bit, so requests keep flowing into empty stages while a
// result waits to be taken. There is no clearing pass after reset. Configuration
// is written on cfg_we with cfg_index and cfg_data, and must only be written
// while no request is in flight.

module ultrasonic_echo_ranger (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                tick_valid,
    output logic                                tick_ready,
    input  uer_pkg::uer_in_t                    tick,
    output logic                                result_valid,
    input  logic                                result_ready,
    output uer_pkg::uer_out_t                   result,
    input  logic                                cfg_we,
    input  logic [uer_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import uer_pkg::*;

    uer_cfg_t   cfg_reg;
    logic       stage_valid;
    logic       stage_ready;
    uer_stage_t stage;

    // Configuration registers; each write truncates the data to the register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_low_ticks <= SETTLE_LOW_RST;
            cfg_reg.pulse_high_ticks <= PULSE_HIGH_RST;
            cfg_reg.timeout_ticks    <= TIMEOUT_RST;
            cfg_reg.scale_factor     <= SCALE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SETTLE_LOW: cfg_reg.settle_low_ticks <= cfg_data[7:0];
                CFG_PULSE_HIGH: cfg_reg.pulse_high_ticks <= cfg_data[7:0];
                CFG_TIMEOUT:    cfg_reg.timeout_ticks    <= cfg_data;
                CFG_SCALE:      cfg_reg.scale_factor     <= cfg_data;
                default:        cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // Sequencer: takes the request, steps the trigger and echo phases and the
    // timer, and registers the control part of the result.
    uer_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_valid  (tick_valid),
        .tick_ready  (tick_ready),
        .tick        (tick),
        .cfg         (cfg_reg),
        .stage_valid (stage_valid),
        .stage_ready (stage_ready),
        .stage       (stage)
    );

    // Scaling stage: converts a completed width to distance and holds the
    // result until it is taken.
    uer_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .scale_factor (cfg_reg.scale_factor),
        .stage_valid  (stage_valid),
        .stage_ready  (stage_ready),
        .stage        (stage),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
